// ===== rtl/core/stts_pkg.sv =====
package stts_pkg;

  // Tag field constants
  localparam logic [31:0] TYPE_MASK  = 32'hFFFF_0000;
  localparam logic [15:0] INDEX_FILL = 16'h2020;
  localparam logic [15:0] INDEX_MASK = 16'hFFFF;

  // Item opcodes
  typedef enum logic [2:0] {
    OP_WRITE      = 3'd0,
    OP_LOOKUP     = 3'd1,
    OP_LOCATE     = 3'd2,
    OP_LOCATE_IDX = 3'd3,
    OP_COUNT      = 3'd4
  } op_t;

  // Configuration register index
  typedef enum logic {
    REG_ENTRY_COUNT  = 1'b0,
    REG_TABLE_SORTED = 1'b1
  } reg_idx_t;

  // Table read address source
  typedef enum logic [1:0] {
    ADDR_PROBE = 2'd0,
    ADDR_WALK  = 2'd1,
    ADDR_IDX   = 2'd2
  } addr_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic      load;
    logic      wr;
    logic      rd_en;
    addr_sel_t addr_sel;
    logic      bs_step;
    logic      half_dec;
    logic      idx_inc;
    logic      cnt_inc;
    logic      set_eq_hit;
    logic      set_tail_hit;
    logic      out_load;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic span_zero;
    logic half_zero;
    logic idx_lt_n;
    logic rd_eq_key;
    logic rd_lt_key;
    logic norm_eq_key;
    logic is_count;
  } dp_sts_t;

  // Indexed entries compare by type with a fixed index fill
  function automatic logic [31:0] normalize(input logic [31:0] tag, input logic indexed);
    logic [31:0] res;
    res = indexed ? ((tag & TYPE_MASK) | {16'h0000, INDEX_FILL}) : tag;
    return res;
  endfunction

endpackage

// ===== rtl/core/sorted_tag_table_search_unit.sv =====
// Sorted tag table search unit.
// Input channel (in_valid/in_ready): op 0 writes one table slot and gives no
// result; ops 1 to 4 (exact lookup, locate type, locate indexed, count type)
// each give one item on the result channel (out_valid/out_ready). Ops 5 to 7
// are taken and dropped.
// APB port: entry_count at address 0, table_sorted at address 4. The user must
// write them only while the unit is idle; the unit itself does not enforce this.
// A write is done in the idle state. A binary search reads and compares each
// probe, walks back over duplicates of an exact hit, checks the final candidate
// when the span runs out and then loads the result. Linear scan and count read
// and compare each entry visited. Each step is bound by one read of the table
// RAM, whose read data is registered.
// One query is in flight at a time; a new item is taken as soon as the
// previous result sits in the output register, even if it is not yet taken.
// A stalled receiver holds the finished query in its last state until the
// output register frees.
// Reset clears the sequencer and output valid, sets entry_count to 0 and
// table_sorted to 1; table contents are undefined until written.
module sorted_tag_table_search_unit
  import stts_pkg::*;
#(
  parameter int TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_op,
  input  logic [7:0]  in_entry_slot,
  input  logic [31:0] in_entry_tag,
  input  logic        in_entry_is_indexed,
  input  logic [31:0] in_search_key,
  input  logic [15:0] in_first_index,
  input  logic [15:0] in_last_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_found,
  output logic [8:0]  out_position,
  output logic [31:0] out_hit_tag,
  output logic [8:0]  out_match_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [8:0] entry_count_r, entry_count_nxt;
  logic       table_sorted_r, table_sorted_nxt;
  logic       reg_wr;
  reg_idx_t   reg_sel;
  dp_cmd_t    cmd;
  dp_sts_t    sts;

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite;
  assign reg_sel = reg_idx_t'(paddr[2]);

  always_comb begin
    entry_count_nxt  = entry_count_r;
    table_sorted_nxt = table_sorted_r;
    if (reg_wr) begin
      unique case (reg_sel)
        REG_ENTRY_COUNT:  entry_count_nxt  = pwdata[8:0];
        REG_TABLE_SORTED: table_sorted_nxt = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r  <= 9'd0;
      table_sorted_r <= 1'b1;
    end else begin
      entry_count_r  <= entry_count_nxt;
      table_sorted_r <= table_sorted_nxt;
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_ENTRY_COUNT:  prdata = {23'd0, entry_count_r};
      REG_TABLE_SORTED: prdata = {31'd0, table_sorted_r};
      default:          prdata = 32'd0;
    endcase
  end

  stts_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .table_sorted (table_sorted_r),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  stts_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_op               (in_op),
    .in_entry_slot       (in_entry_slot),
    .in_entry_tag        (in_entry_tag),
    .in_entry_is_indexed (in_entry_is_indexed),
    .in_search_key       (in_search_key),
    .in_first_index      (in_first_index),
    .in_last_index       (in_last_index),
    .entry_count         (entry_count_r),
    .out_found           (out_found),
    .out_position        (out_position),
    .out_hit_tag         (out_hit_tag),
    .out_match_count     (out_match_count)
  );

endmodule

// ===== rtl/core/stts_datapath.sv =====
module stts_datapath
  import stts_pkg::*;
#(
  parameter int TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_sts_t     sts,
  input  logic [2:0]  in_op,
  input  logic [7:0]  in_entry_slot,
  input  logic [31:0] in_entry_tag,
  input  logic        in_entry_is_indexed,
  input  logic [31:0] in_search_key,
  input  logic [15:0] in_first_index,
  input  logic [15:0] in_last_index,
  input  logic [8:0]  entry_count,
  output logic        out_found,
  output logic [8:0]  out_position,
  output logic [31:0] out_hit_tag,
  output logic [8:0]  out_match_count
);

  localparam int AW = $clog2(TABLE_DEPTH);

  // Table memory: {indexed flag, tag}
  logic [32:0]   mem [TABLE_DEPTH];
  logic [32:0]   rd_data_r;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          slot_ok;

  // Search state
  logic [8:0]  lo_r, lo_nxt;
  logic [8:0]  span_r, span_nxt;
  logic [8:0]  half_r, half_nxt;
  logic [8:0]  n_r, n_nxt;
  logic [8:0]  cnt_r, cnt_nxt;
  logic [31:0] key_r, key_nxt;
  logic [31:0] skey_r, skey_nxt;
  logic [15:0] maxi_r, maxi_nxt;
  logic        is_count_r, is_count_nxt;
  logic        is_idx_r, is_idx_nxt;
  logic        p_valid_r, p_valid_nxt;
  logic [8:0]  p_pos_r, p_pos_nxt;
  logic [31:0] p_tag_r, p_tag_nxt;

  // Output registers
  logic        found_r, found_nxt;
  logic [8:0]  pos_r, pos_nxt;
  logic [31:0] hit_r, hit_nxt;
  logic [8:0]  mcnt_r, mcnt_nxt;

  logic [8:0]  probe_half;
  logic [8:0]  probe_ptr;
  logic [8:0]  eq_pos;
  logic [8:0]  walk_ptr;
  logic [8:0]  rd_ptr;
  logic [8:0]  eff_n;
  logic [31:0] rd_tag;
  logic        rd_flag;
  logic        match;

  // Pointer arithmetic
  assign probe_half = span_r >> 1;
  assign probe_ptr  = lo_r + probe_half;
  assign eq_pos     = lo_r + half_r;
  assign walk_ptr   = eq_pos - 9'd1;
  assign eff_n      = (32'(entry_count) > 32'(TABLE_DEPTH)) ? 9'(TABLE_DEPTH) : entry_count;

  always_comb begin
    unique case (cmd.addr_sel)
      ADDR_PROBE: rd_ptr = probe_ptr;
      ADDR_WALK:  rd_ptr = walk_ptr;
      ADDR_IDX:   rd_ptr = lo_r;
      default:    rd_ptr = lo_r;
    endcase
  end

  assign rd_addr = AW'(rd_ptr);
  assign wr_addr = AW'(in_entry_slot);
  assign slot_ok = 32'(in_entry_slot) < 32'(TABLE_DEPTH);

  // Single write port, registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr && slot_ok) begin
      mem[wr_addr] <= {in_entry_is_indexed, in_entry_tag};
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_tag  = rd_data_r[31:0];
  assign rd_flag = rd_data_r[32];

  // Status to controller
  always_comb begin
    sts.span_zero   = (span_r == 9'd0);
    sts.half_zero   = (half_r == 9'd0);
    sts.idx_lt_n    = (lo_r < n_r);
    sts.rd_eq_key   = (rd_tag == skey_r);
    sts.rd_lt_key   = (rd_tag < skey_r);
    sts.norm_eq_key = (normalize(rd_tag, rd_flag) == skey_r);
    sts.is_count    = is_count_r;
  end

  // Candidate acceptance for the finished query
  always_comb begin
    if (is_idx_r) begin
      match = p_valid_r && (normalize(p_tag_r, 1'b1) == key_r) &&
              ((p_tag_r[15:0] & INDEX_MASK) <= maxi_r);
    end else begin
      match = p_valid_r && (p_tag_r == key_r);
    end
  end

  // Next-state logic
  always_comb begin
    lo_nxt       = lo_r;
    span_nxt     = span_r;
    half_nxt     = half_r;
    n_nxt        = n_r;
    cnt_nxt      = cnt_r;
    key_nxt      = key_r;
    skey_nxt     = skey_r;
    maxi_nxt     = maxi_r;
    is_count_nxt = is_count_r;
    is_idx_nxt   = is_idx_r;
    p_valid_nxt  = p_valid_r;
    p_pos_nxt    = p_pos_r;
    p_tag_nxt    = p_tag_r;
    found_nxt    = found_r;
    pos_nxt      = pos_r;
    hit_nxt      = hit_r;
    mcnt_nxt     = mcnt_r;

    // Query setup
    if (cmd.load) begin
      is_count_nxt = (in_op == OP_COUNT);
      is_idx_nxt   = (in_op == OP_LOCATE_IDX);
      key_nxt      = in_search_key;
      skey_nxt     = (in_op == OP_LOCATE_IDX) ?
                     ((in_search_key & TYPE_MASK) | {16'h0000, in_first_index}) :
                     in_search_key;
      maxi_nxt     = in_last_index;
      n_nxt        = eff_n;
      lo_nxt       = 9'd0;
      span_nxt     = eff_n;
      half_nxt     = 9'd0;
      cnt_nxt      = 9'd0;
      p_valid_nxt  = 1'b0;
      p_pos_nxt    = 9'd0;
      p_tag_nxt    = 32'd0;
    end

    // Halving step on the probe just read
    if (cmd.bs_step) begin
      if (sts.rd_eq_key) begin
        half_nxt = probe_half;
      end else if (sts.rd_lt_key) begin
        lo_nxt   = probe_ptr + 9'd1;
        span_nxt = span_r - 9'd1 - probe_half;
      end else begin
        span_nxt = probe_half;
      end
    end

    // Walk back over duplicates
    if (cmd.half_dec) begin
      half_nxt = half_r - 9'd1;
    end

    // Index advance keeps lo + span constant while span lasts
    if (cmd.idx_inc) begin
      lo_nxt = lo_r + 9'd1;
      if (span_r != 9'd0) begin
        span_nxt = span_r - 9'd1;
      end
    end

    if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + 9'd1;
    end

    if (cmd.set_eq_hit) begin
      p_valid_nxt = 1'b1;
      p_pos_nxt   = eq_pos;
      p_tag_nxt   = skey_r;
    end

    if (cmd.set_tail_hit) begin
      p_valid_nxt = 1'b1;
      p_pos_nxt   = lo_r;
      p_tag_nxt   = rd_tag;
    end

    // Result formatting
    if (cmd.out_load) begin
      if (is_count_r) begin
        found_nxt = (cnt_r != 9'd0);
        pos_nxt   = n_r;
        hit_nxt   = 32'd0;
        mcnt_nxt  = cnt_r;
      end else begin
        found_nxt = match;
        pos_nxt   = match ? p_pos_r : n_r;
        hit_nxt   = p_tag_r;
        mcnt_nxt  = 9'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r   <= 9'd0;
      span_r <= 9'd0;
      n_r    <= 9'd0;
    end else begin
      lo_r   <= lo_nxt;
      span_r <= span_nxt;
      n_r    <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    half_r     <= half_nxt;
    cnt_r      <= cnt_nxt;
    key_r      <= key_nxt;
    skey_r     <= skey_nxt;
    maxi_r     <= maxi_nxt;
    is_count_r <= is_count_nxt;
    is_idx_r   <= is_idx_nxt;
    p_valid_r  <= p_valid_nxt;
    p_pos_r    <= p_pos_nxt;
    p_tag_r    <= p_tag_nxt;
    found_r    <= found_nxt;
    pos_r      <= pos_nxt;
    hit_r      <= hit_nxt;
    mcnt_r     <= mcnt_nxt;
  end

  assign out_found       = found_r;
  assign out_position    = pos_r;
  assign out_hit_tag     = hit_r;
  assign out_match_count = mcnt_r;

  // Search window never reaches past the live entries
  a_window_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, lo_r} + {1'b0, span_r}) <= {1'b0, n_r})
    else $error("search window beyond entry count");

  // An exact hit always lands on a live entry
  a_eq_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.set_eq_hit |-> (eq_pos < n_r))
    else $error("exact hit position beyond entry count");

endmodule

// ===== rtl/core/stts_ctrl.sv =====
module stts_ctrl
  import stts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_op,
  input  logic       table_sorted,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_sts_t    sts,
  output dp_cmd_t    cmd
);

  typedef enum logic [11:0] {
    S_IDLE    = 12'b0000_0000_0001,
    S_B_PROBE = 12'b0000_0000_0010,
    S_B_CMP   = 12'b0000_0000_0100,
    S_W_RD    = 12'b0000_0000_1000,
    S_W_CMP   = 12'b0000_0001_0000,
    S_T_RD    = 12'b0000_0010_0000,
    S_T_CMP   = 12'b0000_0100_0000,
    S_T_RD2   = 12'b0000_1000_0000,
    S_T_GET   = 12'b0001_0000_0000,
    S_S_RD    = 12'b0010_0000_0000,
    S_S_CMP   = 12'b0100_0000_0000,
    S_FINISH  = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.addr_sel = ADDR_IDX;
    in_ready     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_op)
            OP_WRITE: begin
              cmd.wr = 1'b1;
            end
            OP_LOOKUP: begin
              cmd.load  = 1'b1;
              state_nxt = table_sorted ? S_B_PROBE : S_S_RD;
            end
            OP_LOCATE, OP_LOCATE_IDX: begin
              cmd.load  = 1'b1;
              state_nxt = S_B_PROBE;
            end
            OP_COUNT: begin
              cmd.load  = 1'b1;
              state_nxt = S_S_RD;
            end
            default: ;
          endcase
        end
      end
      // Binary search probe
      S_B_PROBE: begin
        if (sts.span_zero) begin
          state_nxt = S_T_RD;
        end else begin
          cmd.rd_en    = 1'b1;
          cmd.addr_sel = ADDR_PROBE;
          state_nxt    = S_B_CMP;
        end
      end
      S_B_CMP: begin
        cmd.bs_step = 1'b1;
        state_nxt   = sts.rd_eq_key ? S_W_RD : S_B_PROBE;
      end
      // Walk back to the first duplicate
      S_W_RD: begin
        if (sts.half_zero) begin
          cmd.set_eq_hit = 1'b1;
          state_nxt      = S_FINISH;
        end else begin
          cmd.rd_en    = 1'b1;
          cmd.addr_sel = ADDR_WALK;
          state_nxt    = S_W_CMP;
        end
      end
      S_W_CMP: begin
        if (sts.rd_eq_key) begin
          cmd.half_dec = 1'b1;
          state_nxt    = S_W_RD;
        end else begin
          cmd.set_eq_hit = 1'b1;
          state_nxt      = S_FINISH;
        end
      end
      // Span exhausted: check candidate, maybe step once
      S_T_RD: begin
        if (sts.idx_lt_n) begin
          cmd.rd_en = 1'b1;
          state_nxt = S_T_CMP;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_T_CMP: begin
        if (sts.rd_lt_key) begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_T_RD2;
        end else begin
          cmd.set_tail_hit = 1'b1;
          state_nxt        = S_FINISH;
        end
      end
      S_T_RD2: begin
        if (sts.idx_lt_n) begin
          cmd.rd_en = 1'b1;
          state_nxt = S_T_GET;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_T_GET: begin
        cmd.set_tail_hit = 1'b1;
        state_nxt        = S_FINISH;
      end
      // Linear scan and type count
      S_S_RD: begin
        if (sts.idx_lt_n) begin
          cmd.rd_en = 1'b1;
          state_nxt = S_S_CMP;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_S_CMP: begin
        if (sts.is_count) begin
          cmd.cnt_inc = sts.norm_eq_key;
          cmd.idx_inc = 1'b1;
          state_nxt   = S_S_RD;
        end else if (sts.rd_eq_key) begin
          cmd.set_tail_hit = 1'b1;
          state_nxt        = S_FINISH;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_S_RD;
        end
      end
      // Hand result to the output register once it is free
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output valid
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // A query leaves idle on the next cycle
  a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_op == OP_LOOKUP || in_op == OP_LOCATE ||
     in_op == OP_LOCATE_IDX || in_op == OP_COUNT)) |=> (state_r != S_IDLE))
    else $error("query accepted but sequencer stayed idle");

  // Never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");

  // A probe compare always follows its read
  a_probe_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_B_CMP) |-> ($past(state_r) == S_B_PROBE))
    else $error("probe compare without read");

endmodule
